### src/rlrb_pkg.sv
// ----------------------------------------------------------------------------
// rlrb_pkg: shared types and constants for the receive line ring buffer
// item layouts, status codes and the controller/datapath interface
// ----------------------------------------------------------------------------
package rlrb_pkg;

  // default store depth in bytes (2..127)
  localparam int DEPTH_DEF = 64;

  // fixed field widths
  localparam int COUNT_W = 7;

  // item kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_LINE_BYTE = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_NOT_STORED = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_NO_LINE   = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  // line end characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // request word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } req_t;

  // response word
  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         line_byte;
    logic               last;
    logic [COUNT_W-1:0] lines_ready;
    logic [COUNT_W-1:0] fill_count;
    logic               overflow_flag;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic push;
    logic clear;
    logic no_line;
    logic start;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic lines_zero;
    logic pop_end;
  } stat_t;

endpackage

### src/rlrb_ctrl.sv
// ----------------------------------------------------------------------------
// rlrb_ctrl: control state machine of the receive line ring buffer
// decodes request words and sequences the byte-by-byte line pop
// ----------------------------------------------------------------------------
module rlrb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  logic [1:0]     kind,
  input  rlrb_pkg::stat_t st,
  output rlrb_pkg::cmd_t  cmd
);
  import rlrb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  // take a word only when idle and the response register can be loaded
  assign req_ready = (state == S_IDLE) && st.out_free;
  assign accept    = req_valid && req_ready;

  // command decode
  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (kind)
        KIND_PUSH:  cmd.push = 1'b1;
        KIND_POP: begin
          if (st.lines_zero) cmd.no_line = 1'b1;
          else               cmd.start   = 1'b1;
        end
        KIND_CLEAR: cmd.clear = 1'b1;
        default: ;
      endcase
    end
    if (state == S_POP && st.out_free) cmd.emit = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.start) state_next = S_POP;
      S_POP:  if (cmd.emit && st.pop_end) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

### src/rlrb_datapath.sv
// ----------------------------------------------------------------------------
// rlrb_datapath: byte store, pointers, counters and response register
// executes push, pop byte, clear and no-line commands
// ----------------------------------------------------------------------------
module rlrb_datapath #(
  parameter int DEPTH = rlrb_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  rlrb_pkg::cmd_t  cmd,
  input  logic [7:0]      rx_byte,
  output rlrb_pkg::stat_t st,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output rlrb_pkg::rsp_t  rsp
);
  import rlrb_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // byte store, every slot is written before it is ever read
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] scan, scan_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] lines, lines_next;
  logic          dropped, dropped_next;
  logic          prev_term, prev_term_next;

  logic       full, almost, is_eol, commit, push_wr, pop_end, load;
  logic [7:0] wbyte;
  logic [2:0] status;
  rsp_t       rsp_d;

  function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // push decode
  assign full    = (held == CW'(DEPTH));
  assign almost  = (held == CW'(DEPTH - 1));
  assign is_eol  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
  assign wbyte   = (is_eol || almost) ? 8'h00 : rx_byte;
  assign commit  = (wbyte != 8'h00) || ((held != '0) && !prev_term);
  assign push_wr = cmd.push && !full && (rx_byte != 8'h00) && commit;

  // line ends on its terminator or when the scan has covered the store
  assign pop_end = (rdata == 8'h00) || (scan == PW'(DEPTH - 1));

  // next state of pointers and counters
  always_comb begin
    wr_ptr_next    = wr_ptr;
    rd_ptr_next    = rd_ptr;
    scan_next      = scan;
    held_next      = held;
    lines_next     = lines;
    dropped_next   = dropped;
    prev_term_next = prev_term;
    status         = ST_NOT_STORED;
    priority if (cmd.clear) begin
      wr_ptr_next    = '0;
      rd_ptr_next    = '0;
      scan_next      = '0;
      held_next      = '0;
      lines_next     = '0;
      dropped_next   = 1'b0;
      prev_term_next = 1'b0;
      status         = ST_CLEARED;
    end else if (cmd.push) begin
      if (full) begin
        dropped_next = 1'b1;
        status       = ST_OVERFLOW;
      end else if (push_wr) begin
        wr_ptr_next    = step(wr_ptr);
        held_next      = held + CW'(1);
        prev_term_next = (wbyte == 8'h00);
        if (wbyte == 8'h00) lines_next = lines + CW'(1);
        status = ST_STORED;
      end
    end else if (cmd.emit) begin
      rd_ptr_next = step(rd_ptr);
      scan_next   = scan + PW'(1);
      if (held != '0) held_next = held - CW'(1);
      if (pop_end) lines_next = lines - CW'(1);
      status = ST_LINE_BYTE;
    end else if (cmd.start) begin
      scan_next = '0;
    end else if (cmd.no_line) begin
      status = ST_NO_LINE;
    end
  end

  // store write and registered read of the slot under the read pointer
  always_ff @(posedge clk) begin
    if (push_wr) mem[wr_ptr] <= wbyte;
    rdata <= mem[rd_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      scan      <= '0;
      held      <= '0;
      lines     <= '0;
      dropped   <= 1'b0;
      prev_term <= 1'b0;
    end else begin
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      scan      <= scan_next;
      held      <= held_next;
      lines     <= lines_next;
      dropped   <= dropped_next;
      prev_term <= prev_term_next;
    end
  end

  // response word
  assign load = cmd.push || cmd.clear || cmd.no_line || cmd.emit;

  always_comb begin
    rsp_d.status        = status;
    rsp_d.line_byte     = cmd.emit ? rdata : 8'h00;
    rsp_d.last          = cmd.emit ? pop_end : 1'b1;
    rsp_d.lines_ready   = COUNT_W'(lines_next);
    rsp_d.fill_count    = COUNT_W'(held_next);
    rsp_d.overflow_flag = dropped_next;
  end

  always_ff @(posedge clk) begin
    if (load) rsp <= rsp_d;
  end

  always_ff @(posedge clk) begin
    if (rst)            rsp_valid <= 1'b0;
    else if (load)      rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  // status to the controller
  assign st.out_free   = !rsp_valid || rsp_ready;
  assign st.lines_zero = (lines == '0);
  assign st.pop_end    = pop_end;

endmodule

### src/rx_line_ring_buffer_top.sv
// Receive line ring buffer. Received bytes are pushed into a DEPTH-byte ring
// store and grouped into zero-terminated lines; CR, LF or a byte landing in
// the last free slot ends a line, zero bytes are ignored and a push into a
// full store is dropped and sets the sticky overflow flag. Push, clear and a
// pop with no line ready each give one response word. A pop of a line of N
// bytes (terminator included) is first accepted and then gives one response
// word per byte, paced by the single registered read port of the store. A
// stalled response side holds the pop. The store itself is not cleared by
// reset or by a clear word; both reset only the pointers, counters and flags,
// and slots are always written before they are read.
// ----------------------------------------------------------------------------
// rx_line_ring_buffer_top: top level of the receive line ring buffer
// joins the control state machine and the datapath
// ----------------------------------------------------------------------------
module rx_line_ring_buffer_top #(
  parameter int DEPTH = rlrb_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rlrb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rlrb_pkg::rsp_t rsp
);
  import rlrb_pkg::*;

  cmd_t  cmd;
  stat_t st;

  rlrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (req.kind),
    .st        (st),
    .cmd       (cmd)
  );

  rlrb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rx_byte   (req.rx_byte),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // counts stay within the store
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.fill_count <= DEPTH) && (rsp.lines_ready <= rsp.fill_count))
    else $error("fill or line count out of range");

  // only line bytes carry data or a continuation
  a_non_line: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_LINE_BYTE) |-> (rsp.line_byte == 8'h00) && rsp.last)
    else $error("non line response with data or without last");

  // a drop always shows the sticky flag
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_OVERFLOW) |-> rsp.overflow_flag)
    else $error("overflow drop without flag");

  // no new word is taken in the middle of a line pop
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !st.pop_end |=> !req_ready)
    else $error("request taken during line pop");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the receive line ring buffer
// drives push, pop and clear words with random gaps and random response
// stalls, predicts every response word in a local line store and checks
// each accepted response field by field in order
// ----------------------------------------------------------------------------
module testbench;
  import rlrb_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 28;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // idling control shared by the sender and the receiver
  bit no_idle = 1'b0;
  logic pressure_armed = 1'b0;
  int error_count = 0;

  // predicted line store and its bookkeeping
  logic [7:0] line_mem [DEPTH];
  int wr_slot = 0;
  int rd_slot = 0;
  int last_slot = 0;
  int bytes_held = 0;
  int lines_held = 0;
  logic overflow_seen = 1'b0;
  rsp_t awaited_rsp_q [$];

  rx_line_ring_buffer_top #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // queue one predicted response word from the current line store state
  task automatic queue_rsp(input logic [2:0] st, input logic [7:0] b, input logic fin);
    rsp_t w;
    w.status        = st;
    w.line_byte     = b;
    w.last          = fin;
    w.lines_ready   = lines_held[COUNT_W-1:0];
    w.fill_count    = bytes_held[COUNT_W-1:0];
    w.overflow_flag = overflow_seen;
    awaited_rsp_q.push_back(w);
  endtask

  // work out the response words for one accepted request word
  task automatic predict_rx_word(input req_t w);
    logic [7:0] v;
    logic [7:0] b;
    bit commit;
    bit done;
    int i;
    case (w.kind)
      KIND_PUSH: begin
        if (bytes_held >= DEPTH) begin
          overflow_seen = 1'b1;
          queue_rsp(ST_OVERFLOW, 8'h00, 1'b1);
        end else if (w.rx_byte == 8'h00) begin
          queue_rsp(ST_NOT_STORED, 8'h00, 1'b1);
        end else begin
          v = w.rx_byte;
          // line end characters and the last free slot turn into a terminator
          if (v == CHAR_CR || v == CHAR_LF || bytes_held == DEPTH - 1) v = 8'h00;
          commit = (v != 8'h00) || (bytes_held > 0 && line_mem[last_slot] != 8'h00);
          if (!commit) begin
            queue_rsp(ST_NOT_STORED, 8'h00, 1'b1);
          end else begin
            line_mem[wr_slot] = v;
            last_slot = wr_slot;
            bytes_held++;
            wr_slot = (wr_slot + 1) % DEPTH;
            if (v == 8'h00) lines_held++;
            queue_rsp(ST_STORED, 8'h00, 1'b1);
          end
        end
      end
      KIND_POP: begin
        if (lines_held == 0) begin
          queue_rsp(ST_NO_LINE, 8'h00, 1'b1);
        end else begin
          done = 1'b0;
          for (i = 0; i < DEPTH && !done; i++) begin
            b = line_mem[rd_slot];
            done = (b == 8'h00) || (i == DEPTH - 1);
            rd_slot = (rd_slot + 1) % DEPTH;
            if (bytes_held > 0) bytes_held--;
            if (done) lines_held--;
            queue_rsp(ST_LINE_BYTE, b, done);
          end
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < DEPTH; i++) line_mem[i] = 8'h00;
        wr_slot = 0;
        rd_slot = 0;
        last_slot = 0;
        bytes_held = 0;
        lines_held = 0;
        overflow_seen = 1'b0;
        queue_rsp(ST_CLEARED, 8'h00, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // predict on accepted request words, then check accepted response words
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) predict_rx_word(req);
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp_q.size() == 0) begin
          $display("%0t: unexpected response word, expected none, actual %h", $time, rsp);
          error_count++;
        end else begin
          want = awaited_rsp_q.pop_front();
          compare_field("status", 8'(want.status), 8'(rsp.status));
          compare_field("line_byte", want.line_byte, rsp.line_byte);
          compare_field("last", 8'(want.last), 8'(rsp.last));
          compare_field("lines_ready", 8'(want.lines_ready), 8'(rsp.lines_ready));
          compare_field("fill_count", 8'(want.fill_count), 8'(rsp.fill_count));
          compare_field("overflow_flag", 8'(want.overflow_flag), 8'(rsp.overflow_flag));
        end
      end
    end
  end

  // response side: random stalls, or one long hold-off when armed
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_armed) begin
        pressure_armed <= 1'b0;
        rsp_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // send one request word, returns at the edge that accepts it
  task automatic send_word(input logic [1:0] k, input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req.kind <= k;
    req.rx_byte <= b;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // nonzero byte that is neither CR nor LF
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (b == CHAR_CR || b == CHAR_LF) b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  // mostly line text and line ends, with pops and some noise
  task automatic send_random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 58)      send_word(KIND_PUSH, text_byte());
    else if (pick < 70) send_word(KIND_PUSH, $urandom_range(1) ? CHAR_CR : CHAR_LF);
    else if (pick < 73) send_word(KIND_PUSH, 8'h00);
    else if (pick < 89) send_word(KIND_POP, 8'($urandom_range(255)));
    else if (pick < 90) send_word(KIND_CLEAR, 8'($urandom_range(255)));
    else if (pick < 92) send_word(KIND_UNUSED, 8'($urandom_range(255)));
    else                send_word(KIND_PUSH, 8'($urandom_range(255)));
  endtask

  // line end handling, repeated terminators, zero bytes, empty pops
  task automatic test_line_basics();
    send_word(KIND_CLEAR, 8'hAA);
    send_word(KIND_POP, 8'h00);
    send_word(KIND_PUSH, CHAR_LF);
    send_word(KIND_PUSH, 8'h00);
    send_word(KIND_PUSH, 8'h41);
    send_word(KIND_PUSH, 8'hFF);
    send_word(KIND_PUSH, 8'h01);
    send_word(KIND_PUSH, 8'h80);
    send_word(KIND_PUSH, CHAR_CR);
    send_word(KIND_PUSH, CHAR_LF);
    send_word(KIND_PUSH, CHAR_CR);
    send_word(KIND_PUSH, 8'h7F);
    send_word(KIND_PUSH, CHAR_LF);
    send_word(KIND_UNUSED, 8'h55);
    send_word(KIND_POP, 8'hFF);
    send_word(KIND_POP, 8'h00);
    send_word(KIND_POP, 8'h00);
    send_word(KIND_PUSH, 8'hFE);
    send_word(KIND_CLEAR, 8'h00);
  endtask

  // full store with overflow drops, then a store stuck one short of full
  task automatic test_fill_and_overflow();
    int i;
    send_word(KIND_CLEAR, 8'($urandom_range(255)));
    for (i = 0; i < DEPTH; i++) send_word(KIND_PUSH, text_byte());
    send_word(KIND_PUSH, 8'h00);
    send_word(KIND_PUSH, 8'($urandom_range(255)));
    send_word(KIND_PUSH, CHAR_CR);
    send_word(KIND_POP, 8'($urandom_range(255)));
    for (i = 0; i < DEPTH - 2; i++) send_word(KIND_PUSH, text_byte());
    send_word(KIND_PUSH, CHAR_LF);
    for (i = 0; i < 3; i++) send_word(KIND_PUSH, 8'($urandom_range(1, 255)));
    send_word(KIND_POP, 8'($urandom_range(255)));
    send_word(KIND_PUSH, text_byte());
    send_word(KIND_PUSH, CHAR_CR);
    send_word(KIND_POP, 8'($urandom_range(255)));
    send_word(KIND_CLEAR, 8'($urandom_range(255)));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_word();
  endtask

  // long response hold-off while words keep coming, so the input stalls
  task automatic test_response_backpressure();
    pressure_armed <= 1'b1;
    repeat (40) send_random_word();
  endtask

  // back to back words with the response side always ready
  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    repeat (50) send_random_word();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_line_basics();
    test_random_traffic(35);
    test_fill_and_overflow();
    test_response_backpressure();
    test_no_idle_stretch();
    test_random_traffic(35);
    req_valid <= 1'b0;
    // drain the outstanding responses
    @(negedge clk);
    while (awaited_rsp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
